// File: hw/rtl/lhp_pkg.sv
`default_nettype none

package lhp_pkg;

  localparam int unsigned PC_W = 32;

  localparam int unsigned HISTORY_ENTRIES_DEF = 512;
  localparam int unsigned HISTORY_BITS_DEF    = 6;
  localparam int unsigned PATTERN_TABLES_DEF  = 8;

  localparam int unsigned CTR_W = 2;
  localparam logic [CTR_W-1:0] CTR_RESET     = 2'd1;
  localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
  localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;
  localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 2'd2;

  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_HIST,
    ST_CTR,
    ST_UPDATE
  } state_t;

  function automatic bit is_pow2(input int unsigned x);
    return (x != 0) && ((x & (x - 1)) == 0);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lhp_index.sv
`default_nettype none

// Splits a branch address into pattern table and history register indexes.
// When both table counts are powers of two these are plain bit fields;
// otherwise each of the two divisions goes through a reciprocal multiply whose
// quotient is at most one low, then one compare and subtract (six steps in all).
module lhp_index #(
  parameter int unsigned HISTORY_ENTRIES = lhp_pkg::HISTORY_ENTRIES_DEF,
  parameter int unsigned PATTERN_TABLES  = lhp_pkg::PATTERN_TABLES_DEF,
  localparam int unsigned TBL_W  = (PATTERN_TABLES > 1) ? $clog2(PATTERN_TABLES) : 1,
  localparam int unsigned HIDX_W = $clog2(HISTORY_ENTRIES)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lhp_pkg::PC_W-1:0] pc,
  output logic                          done,
  output logic [TBL_W-1:0]              tbl,
  output logic [HIDX_W-1:0]             hidx
);
  import lhp_pkg::*;

  localparam bit FAST = is_pow2(PATTERN_TABLES) && is_pow2(HISTORY_ENTRIES);

  generate
    if (FAST) begin : g_fields
      localparam int unsigned TSHIFT = $clog2(PATTERN_TABLES);
      logic [PC_W-1:0] pc_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          pc_q <= '0;
        end else if (start) begin
          pc_q <= pc;
        end
      end

      if (PATTERN_TABLES == 1) begin : g_one
        assign tbl = '0;
      end else begin : g_many
        assign tbl = pc_q[TBL_W-1:0];
      end
      assign hidx = pc_q[TSHIFT +: HIDX_W];
      assign done = 1'b1;
    end else begin : g_divide
      localparam logic [PC_W-1:0] PC_MAX  = '1;
      localparam logic [PC_W-1:0] T_DIV   = PC_W'(PATTERN_TABLES);
      localparam logic [PC_W-1:0] H_DIV   = PC_W'(HISTORY_ENTRIES);
      // floor((2**PC_W - 1) / d) keeps each estimate within one of the true
      // quotient, including a divisor of one.
      localparam logic [PC_W-1:0] T_RECIP = PC_MAX / T_DIV;
      localparam logic [PC_W-1:0] H_RECIP = PC_MAX / H_DIV;

      logic [5:0]        stage;
      logic [PC_W-1:0]   pc_q;
      logic [PC_W-1:0]   t_est;
      logic [PC_W-1:0]   t_rem;
      logic [PC_W-1:0]   t_quo;
      logic [PC_W-1:0]   h_est;
      logic [PC_W-1:0]   h_rem;
      logic [TBL_W-1:0]  tbl_q;
      logic [HIDX_W-1:0] hidx_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
        end else if (start) begin
          stage <= 6'b000001;
        end else begin
          stage <= stage << 1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          pc_q <= pc;
        end
        if (stage[0]) begin
          t_est <= PC_W'(((2*PC_W)'(pc_q) * (2*PC_W)'(T_RECIP)) >> PC_W);
        end
        if (stage[1]) begin
          t_rem <= pc_q - t_est * T_DIV;
        end
        if (stage[2]) begin
          if (t_rem >= T_DIV) begin
            t_quo <= t_est + 1'b1;
            tbl_q <= TBL_W'(t_rem - T_DIV);
          end else begin
            t_quo <= t_est;
            tbl_q <= TBL_W'(t_rem);
          end
        end
        if (stage[3]) begin
          h_est <= PC_W'(((2*PC_W)'(t_quo) * (2*PC_W)'(H_RECIP)) >> PC_W);
        end
        if (stage[4]) begin
          h_rem <= t_quo - h_est * H_DIV;
        end
        if (stage[5]) begin
          hidx_q <= (h_rem >= H_DIV) ? HIDX_W'(h_rem - H_DIV) : HIDX_W'(h_rem);
        end
      end

      assign done = (stage == '0);
      assign tbl  = tbl_q;
      assign hidx = hidx_q;
    end
  endgenerate

endmodule

`default_nettype wire

// File: hw/rtl/local_history_two_level_predictor.sv
`default_nettype none

// Channel   Handshake             Payload
// req       req_valid/req_stall   func, pc, resolved_taken
// rsp       rsp_valid/rsp_stall   predicted_taken
//
// One request at a time: index, history read, counter read and update run
// before the next request transfer; the update waits while a result is stalled.
// Unless both table counts are powers of two, the index split adds six divide steps.
// After reset a clearing pass over max(HISTORY_ENTRIES,
// PATTERN_TABLES * 2**HISTORY_BITS) entries (512 by default) holds req_stall high.
// A result register lets the next request transfer while a result is stalled.
module local_history_two_level_predictor #(
  parameter int unsigned HISTORY_ENTRIES = lhp_pkg::HISTORY_ENTRIES_DEF,
  parameter int unsigned HISTORY_BITS    = lhp_pkg::HISTORY_BITS_DEF,
  parameter int unsigned PATTERN_TABLES  = lhp_pkg::PATTERN_TABLES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_stall,
  input  wire logic                     func,
  input  wire logic [lhp_pkg::PC_W-1:0] pc,
  input  wire logic                     resolved_taken,
  output logic                          rsp_valid,
  input  wire logic                     rsp_stall,
  output logic                          predicted_taken
);
  import lhp_pkg::*;

  localparam int unsigned TBL_W  = (PATTERN_TABLES > 1) ? $clog2(PATTERN_TABLES) : 1;
  localparam int unsigned HIDX_W = $clog2(HISTORY_ENTRIES);
  localparam int unsigned CT     = PATTERN_TABLES * (2 ** HISTORY_BITS);
  localparam int unsigned CT_AW  = $clog2(CT);
  localparam int unsigned CLR_N  = (HISTORY_ENTRIES > CT) ? HISTORY_ENTRIES : CT;
  localparam int unsigned CLR_W  = $clog2(CLR_N);

  state_t state, state_next;

  logic [CLR_W-1:0] clr_cnt;
  logic             clr_last;
  logic             func_q;
  logic             taken_q;

  logic              idx_start;
  logic              idx_done;
  logic [TBL_W-1:0]  tbl;
  logic [HIDX_W-1:0] hidx;

  logic [HISTORY_BITS-1:0] hist_mem [HISTORY_ENTRIES];
  logic [CTR_W-1:0]        ctr_mem  [CT];

  logic                    h_en, h_we;
  logic [HIDX_W-1:0]       h_addr;
  logic [HISTORY_BITS-1:0] h_wdata, h_rdata;
  logic                    c_en, c_we;
  logic [CT_AW-1:0]        c_addr;
  logic [CTR_W-1:0]        c_wdata, c_rdata;

  logic             accept;
  logic             out_free;
  logic             rsp_load;
  logic [CT_AW-1:0] slot;
  logic [CTR_W-1:0] ctr_upd;

  lhp_index #(
    .HISTORY_ENTRIES(HISTORY_ENTRIES),
    .PATTERN_TABLES (PATTERN_TABLES)
  ) u_index (
    .clk  (clk),
    .rst  (rst),
    .start(idx_start),
    .pc   (pc),
    .done (idx_done),
    .tbl  (tbl),
    .hidx (hidx)
  );

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign clr_last = clr_cnt == CLR_W'(CLR_N - 1);
  assign slot     = CT_AW'({tbl, h_rdata});

  always_comb begin
    priority if (taken_q) begin
      ctr_upd = (c_rdata == CTR_MAX) ? c_rdata : c_rdata + 1'b1;
    end else begin
      ctr_upd = (c_rdata == CTR_MIN) ? c_rdata : c_rdata - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_INDEX;
      ST_INDEX:  if (idx_done) state_next = ST_HIST;
      ST_HIST:   state_next = ST_CTR;
      ST_CTR:    state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    idx_start = 1'b0;
    h_en      = 1'b0;
    h_we      = 1'b0;
    h_addr    = hidx;
    h_wdata   = HISTORY_BITS'({h_rdata, taken_q});
    c_en      = 1'b0;
    c_we      = 1'b0;
    c_addr    = slot;
    c_wdata   = ctr_upd;
    rsp_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        h_addr  = HIDX_W'(clr_cnt);
        h_wdata = '0;
        h_en    = {1'b0, clr_cnt} < (CLR_W + 1)'(HISTORY_ENTRIES);
        h_we    = h_en;
        c_addr  = CT_AW'(clr_cnt);
        c_wdata = CTR_RESET;
        c_en    = {1'b0, clr_cnt} < (CLR_W + 1)'(CT);
        c_we    = c_en;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        idx_start = accept;
      end
      ST_INDEX: begin
      end
      ST_HIST: begin
        h_en = 1'b1;
      end
      ST_CTR: begin
        c_en = 1'b1;
      end
      ST_UPDATE: begin
        // On an update request both tables are written back in the cycle the result is loaded.
        rsp_load = out_free;
        h_en     = out_free && (func_q == FUNC_UPDATE);
        h_we     = h_en;
        c_en     = h_en;
        c_we     = h_en;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func;
      taken_q <= resolved_taken;
    end
  end

  always_ff @(posedge clk) begin
    if (h_en) begin
      if (h_we) begin
        hist_mem[h_addr] <= h_wdata;
      end else begin
        h_rdata <= hist_mem[h_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      if (c_we) begin
        ctr_mem[c_addr] <= c_wdata;
      end else begin
        c_rdata <= ctr_mem[c_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      predicted_taken <= c_rdata >= CTR_TAKEN_MIN;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lhp_checker.sv
`default_nettype none

module lhp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire logic predicted_taken
);

  // The table clearing pass follows every reset.
  a_stall_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request taken during table clearing");

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request taken while one is in flight");

  // A result needs at least the two table reads after its request.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> !$rose(rsp_valid))
    else $error("result appeared too soon after a request transfer");

  // A new result only comes out of a busy cycle.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared without a request being worked on");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(predicted_taken)))
    else $error("stalled result changed or dropped");

endmodule

bind local_history_two_level_predictor lhp_checker u_lhp_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .predicted_taken(predicted_taken)
);

`default_nettype wire
